// ===== rtl/core/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Rangefinder frame parser package
// Shared phase encoding, result kinds, register indexes and field types.
// ----------------------------------------------------------------------------
package rfp_pkg;

	// Frame parse phase
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HDR2 = 3'd1,
		PH_HDR3 = 3'd2,
		PH_KIND = 3'd3,
		PH_DIST = 3'd4,
		PH_ERR  = 3'd5,
		PH_CSD  = 3'd6,
		PH_CSE  = 3'd7
	} rfp_phase_t;

	// Result kind codes
	localparam logic [1:0] KIND_DISTANCE = 2'd0;
	localparam logic [1:0] KIND_ERROR    = 2'd1;
	localparam logic [1:0] KIND_DISCARD  = 2'd2;

	// Input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_FINE    = 2'd0;
	localparam logic [1:0] REG_OFFSET  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	// Frame bytes
	localparam logic [7:0] HDR_BYTE1  = 8'h80;
	localparam logic [7:0] HDR_BYTE2  = 8'h06;
	localparam logic [7:0] HDR_BYTE3  = 8'h83;
	localparam logic [7:0] ERR_LEAD   = 8'h45;
	localparam logic [7:0] POINT_CHAR = 8'h2E;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	// Frame positions (bytes held, header included)
	localparam logic [3:0] POS_POINT     = 4'd7;
	localparam logic [3:0] POS_LAST_STD  = 4'd10;
	localparam logic [3:0] POS_LAST_FINE = 4'd11;
	localparam logic [3:0] POS_TEXT0     = 4'd4;
	localparam logic [3:0] HELD_MAX      = 4'd15;

	localparam logic [13:0] METRE_SCALE   = 14'd10000;
	localparam logic [7:0]  TIMEOUT_RESET = 8'd10;
	localparam logic [7:0]  SILENCE_MAX   = 8'd255;

	localparam int TDATA_W = 96;
	localparam int CFG_W   = 21;

	typedef struct packed {
		logic              fine;
		logic [20:0]       offset;
		logic [7:0]        timeout;
	} rfp_cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic signed [24:0] distance;
		logic [63:0]       text;
		logic [3:0]        discarded;
	} rfp_result_t;

endpackage

// ===== rtl/core/rfp_parser.sv =====
// ----------------------------------------------------------------------------
// Rangefinder frame parser core
// Holds the frame state and turns one registered item into at most one result.
// ----------------------------------------------------------------------------
module rfp_parser
	import rfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        operation,
	input  logic [7:0]  rx_byte,
	input  rfp_cfg_t    cfg,
	output logic        emit,
	output rfp_result_t result
);

	rfp_phase_t  phase_q, phase_d;
	logic [3:0]  held_q, held_d;
	logic [7:0]  sum_q, sum_d;
	logic [9:0]  whole_q, whole_d;
	logic [13:0] frac_q, frac_d;
	logic [63:0] text_q, text_d;
	logic [7:0]  silence_q, silence_d;

	logic        is_digit;
	logic [3:0]  digit;
	logic [3:0]  held_inc;
	logic [3:0]  last_pos;
	logic [7:0]  limit;
	logic [7:0]  silence_inc;
	logic [3:0]  lane_pos;
	logic [2:0]  lane;
	logic        check_good;
	logic [23:0] whole_term;
	logic [17:0] frac_term;
	logic [24:0] dist_sum;

	assign is_digit    = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
	assign digit       = rx_byte[3:0];
	assign held_inc    = (held_q < HELD_MAX) ? held_q + 4'd1 : held_q;
	assign last_pos    = cfg.fine ? POS_LAST_FINE : POS_LAST_STD;
	assign limit       = (cfg.timeout == 8'd0) ? 8'd1 : cfg.timeout;
	assign silence_inc = (silence_q < SILENCE_MAX) ? silence_q + 8'd1 : silence_q;
	assign lane_pos    = held_inc - POS_TEXT0;
	assign lane        = lane_pos[2:0];
	assign check_good  = ((8'd0 - sum_q) == rx_byte);

	// Scale the distance: metres, fraction (times ten when only three decimals
	// came, so the check byte sits at position eleven), offset
	assign whole_term = 24'(whole_q) * 24'(METRE_SCALE);
	assign frac_term  = (held_inc == POS_LAST_FINE) ? 18'(frac_q) * 18'd10
	                                                : 18'(frac_q);
	assign dist_sum   = 25'(whole_term) + 25'(frac_term)
	                  + {{4{cfg.offset[20]}}, cfg.offset};

	// Next state and result for one item
	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		sum_d     = sum_q;
		whole_d   = whole_q;
		frac_d    = frac_q;
		text_d    = text_q;
		silence_d = silence_q;
		emit      = 1'b0;
		result    = '0;

		if (operation == OP_TICK) begin
			silence_d = silence_inc;
			if (silence_inc >= limit) begin
				silence_d = 8'd0;
				phase_d   = PH_HUNT;
				if (held_q != 4'd0) begin
					held_d           = 4'd0;
					sum_d            = 8'd0;
					emit             = 1'b1;
					result.kind      = KIND_DISCARD;
					result.discarded = held_q;
				end
			end
		end else if (phase_q == PH_HUNT) begin
			silence_d = 8'd0;
			if (rx_byte == HDR_BYTE1) begin
				held_d  = 4'd1;
				sum_d   = HDR_BYTE1;
				whole_d = '0;
				frac_d  = '0;
				text_d  = '0;
				phase_d = PH_HDR2;
				if (held_q != 4'd0) begin
					emit             = 1'b1;
					result.kind      = KIND_DISCARD;
					result.discarded = held_q;
				end
			end
		end else begin
			silence_d = 8'd0;
			held_d    = held_inc;
			sum_d     = sum_q + rx_byte;
			case (phase_q)
				PH_HDR2: phase_d = (rx_byte == HDR_BYTE2) ? PH_HDR3 : PH_HUNT;
				PH_HDR3: phase_d = (rx_byte == HDR_BYTE3) ? PH_KIND : PH_HUNT;
				PH_KIND: begin
					if (is_digit) begin
						whole_d = 10'(digit);
						phase_d = PH_DIST;
					end else if (rx_byte == ERR_LEAD) begin
						text_d  = 64'(ERR_LEAD);
						phase_d = PH_ERR;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_DIST: begin
					if (held_inc == POS_POINT) begin
						if (rx_byte != POINT_CHAR) phase_d = PH_HUNT;
					end else if (held_inc < POS_LAST_FINE
						|| (cfg.fine && held_inc < POS_LAST_FINE + 4'd1)) begin
						if (!is_digit) begin
							phase_d = PH_HUNT;
						end else begin
							if (held_inc < POS_POINT)
								whole_d = 10'(({whole_q, 3'b000} + {whole_q, 1'b0})
								        + 13'(digit));
							else
								frac_d = 14'(({frac_q, 3'b000} + {frac_q, 1'b0})
								       + 17'(digit));
							if (held_inc == last_pos) phase_d = PH_CSD;
						end
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_ERR: begin
					// Place text bytes two through eight of the frame body
					if (held_inc >= POS_TEXT0 && held_inc <= POS_LAST_FINE) begin
						for (int i = 0; i < 8; i++) begin
							if (lane == 3'(i)) text_d[8*i +: 8] = text_q[8*i +: 8] | rx_byte;
						end
					end
					if (held_inc >= last_pos) phase_d = PH_CSE;
				end
				PH_CSD, PH_CSE: begin
					phase_d = PH_HUNT;
					if (check_good) begin
						held_d = 4'd0;
						sum_d  = 8'd0;
						emit   = 1'b1;
						if (phase_q == PH_CSD) begin
							result.kind     = KIND_DISTANCE;
							result.distance = dist_sum;
						end else begin
							result.kind = KIND_ERROR;
							result.text = text_q;
						end
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// Frame state registers; advance only when an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			held_q    <= '0;
			sum_q     <= '0;
			whole_q   <= '0;
			frac_q    <= '0;
			text_q    <= '0;
			silence_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			held_q    <= held_d;
			sum_q     <= sum_d;
			whole_q   <= whole_d;
			frac_q    <= frac_d;
			text_q    <= text_d;
			silence_q <= silence_d;
		end
	end

endmodule

// ===== rtl/core/rangefinder_ascii_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// Rangefinder ASCII frame parser, top level
// Parses header 80 06 83 frames carrying an ASCII distance or error text.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata rx_byte, tuser operation
// m_*       out  m_tvalid/m_tready  tdata distance/text/count, tuser kind
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle is taken while the result side does not stall; its result
// passes through the input register and then the result register.
// The input register and the result register are the only stages; the frame
// state updates in the single step between them.
// A stalled result holds the input stage, which then backs up s_tready.
// Reset clears the frame state and both stage valid flags, and returns the registers to their reset values.
// ----------------------------------------------------------------------------
module rangefinder_ascii_frame_parser_top
	import rfp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] rx_byte
	input  logic                s_tuser,   // [0] operation
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata,   // [24:0] distance_tenth_mm,
	                                       // [88:25] error_text,
	                                       // [92:89] discarded_bytes, [95:93] zero
	output logic [1:0]          m_tuser,   // [1:0] frame_kind
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	rfp_cfg_t    cfg_q;
	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        advance_s1;
	logic        emit;
	rfp_result_t result;
	rfp_result_t result_q;
	logic        m_valid_q;

	assign cfg_ready  = 1'b1;
	assign advance_s1 = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fine    <= 1'b0;
			cfg_q.offset  <= '0;
			cfg_q.timeout <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FINE:    cfg_q.fine    <= cfg_data[0];
				REG_OFFSET:  cfg_q.offset  <= cfg_data[20:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	rfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.operation (op_s1),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.emit      (emit),
		.result    (result)
	);

	// Result register valid: load on a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance_s1 && emit) result_q <= result;
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = result_q.kind;
	assign m_tdata  = {3'b000, result_q.discarded, result_q.text, result_q.distance};

endmodule

// ===== dv/rangefinder_ascii_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rangefinder ASCII frame parser testbench
// Feeds received bytes and millisecond ticks through the input stream, keeps
// its own model of the frame parser and checks every result word field by
// field. A short table of directed words runs first. Random phases follow,
// each under new register settings, built mostly from good and broken frames.
// ----------------------------------------------------------------------------
module rangefinder_ascii_frame_parser_top_tb;
	import rfp_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 120;
	localparam int SETTLE_CYCLES = 4;

	// Index with no register behind it
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic        op;
		logic [7:0]  data;
		logic        pinned;
		rfp_result_t res;
	} dir_row_t;

	localparam rfp_result_t NO_RESULT = '0;

	// Directed words; pinned rows carry the result they must produce
	localparam dir_row_t DIRECTED [26] = '{
		'{OP_TICK, 8'h00, 1'b0, NO_RESULT},
		// largest 1 mm distance, 999.999
		'{OP_BYTE, 8'h80, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h06, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h83, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h39, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h39, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h39, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h2E, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h39, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h39, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h39, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h73, 1'b1, '{KIND_DISTANCE, 25'sd9999990, 64'd0, 4'd0}},
		// error frame with all-ones and all-zeros text bytes
		'{OP_BYTE, 8'h80, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h06, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h83, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h45, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'hFF, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h00, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'hFF, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h00, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'hFF, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h00, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'hB5, 1'b1, '{KIND_ERROR, 25'sd0, 64'h0000_FF00_FF00_FF45, 4'd0}},
		// broken header, then a new header reports the two held bytes
		'{OP_BYTE, 8'h80, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h41, 1'b0, NO_RESULT},
		'{OP_BYTE, 8'h80, 1'b1, '{KIND_DISCARD, 25'sd0, 64'd0, 4'd2}}
	};

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata   = '0;
	logic               s_tuser   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0]         m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;

	// Sidecar of the word on the input: a pinned result replaces the prediction
	logic               pin_on    = 1'b0;
	rfp_result_t        pin_res   = '0;

	rfp_result_t        pending_frames[$];
	int                 mismatches  = 0;
	int                 words_sent  = 0;
	int                 cycle_count = 0;
	int                 stall_left  = 0;
	bit                 gaps_on     = 1'b1;
	bit                 calm        = 1'b0;

	// Parser model: register copies and frame state
	logic               set_fine    = 1'b0;
	logic [20:0]        set_offset  = '0;
	logic [7:0]         set_timeout = TIMEOUT_RESET;
	rfp_phase_t         par_phase   = PH_HUNT;
	logic [3:0]         par_held    = '0;
	logic [7:0]         par_sum     = '0;
	logic [9:0]         par_metres  = '0;
	logic [13:0]        par_frac    = '0;
	logic [63:0]        par_text    = '0;
	logic [7:0]         par_quiet   = '0;

	rangefinder_ascii_frame_parser_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit is_digit(input logic [7:0] b);
		return b >= DIGIT_ZERO && b <= DIGIT_NINE;
	endfunction

	// Advance the parser model by one word; flag and return any result
	function automatic void parse_rx_word(input logic op, input logic [7:0] b,
	                                      output bit produced, output rfp_result_t res);
		logic [3:0] last_pos;
		logic [3:0] pos;
		logic [7:0] limit;
		logic [7:0] prior;
		rfp_phase_t closing;
		int         scale;
		int         offset_int;
		int         dist_val;
		produced = 1'b0;
		res      = '0;
		last_pos = set_fine ? POS_LAST_FINE : POS_LAST_STD;

		// Tick: count silence, drop held bytes once the line stays quiet
		if (op == OP_TICK) begin
			limit = (set_timeout == 8'd0) ? 8'd1 : set_timeout;
			if (par_quiet < SILENCE_MAX)
				par_quiet = par_quiet + 8'd1;
			if (par_quiet >= limit) begin
				par_quiet = '0;
				par_phase = PH_HUNT;
				if (par_held != 0) begin
					produced      = 1'b1;
					res.kind      = KIND_DISCARD;
					res.discarded = par_held;
					par_held      = '0;
					par_sum       = '0;
				end
			end
			return;
		end

		par_quiet = '0;

		// Hunting: only a first header byte matters, and it flushes held bytes
		if (par_phase == PH_HUNT) begin
			if (b == HDR_BYTE1) begin
				if (par_held != 0) begin
					produced      = 1'b1;
					res.kind      = KIND_DISCARD;
					res.discarded = par_held;
				end
				par_held   = 4'd1;
				par_sum    = HDR_BYTE1;
				par_metres = '0;
				par_frac   = '0;
				par_text   = '0;
				par_phase  = PH_HDR2;
			end
			return;
		end

		prior = par_sum;
		if (par_held < HELD_MAX)
			par_held = par_held + 4'd1;
		pos     = par_held;
		par_sum = par_sum + b;

		case (par_phase)
			PH_HDR2: par_phase = (b == HDR_BYTE2) ? PH_HDR3 : PH_HUNT;
			PH_HDR3: par_phase = (b == HDR_BYTE3) ? PH_KIND : PH_HUNT;
			PH_KIND: begin
				if (is_digit(b)) begin
					par_metres = 10'(b - DIGIT_ZERO);
					par_phase  = PH_DIST;
				end else if (b == ERR_LEAD) begin
					par_text  = 64'(ERR_LEAD);
					par_phase = PH_ERR;
				end else begin
					par_phase = PH_HUNT;
				end
			end
			PH_DIST: begin
				if (pos == POS_POINT) begin
					if (b != POINT_CHAR)
						par_phase = PH_HUNT;
				end else if (pos <= last_pos) begin
					if (!is_digit(b)) begin
						par_phase = PH_HUNT;
					end else begin
						if (pos < POS_POINT)
							par_metres = 10'(par_metres * 10 + (b - DIGIT_ZERO));
						else
							par_frac = 14'(par_frac * 10 + (b - DIGIT_ZERO));
						if (pos == last_pos)
							par_phase = PH_CSD;
					end
				end else begin
					// frame already longer than the current resolution allows
					par_phase = PH_HUNT;
				end
			end
			PH_ERR: begin
				if (pos >= POS_TEXT0 && pos <= POS_LAST_FINE)
					par_text = par_text | (64'(b) << (8 * (pos - POS_TEXT0)));
				if (pos >= last_pos)
					par_phase = PH_CSE;
			end
			PH_CSD, PH_CSE: begin
				closing   = par_phase;
				par_phase = PH_HUNT;
				// check byte makes the byte sum of the whole frame zero
				if (b == 8'(8'h00 - prior)) begin
					par_held = '0;
					par_sum  = '0;
					produced = 1'b1;
					if (closing == PH_CSD) begin
						// check byte at position 11 means only three decimals came
						scale        = (pos == POS_LAST_FINE) ? 10 : 1;
						offset_int   = {{11{set_offset[20]}}, set_offset};
						dist_val     = int'(par_metres) * int'(METRE_SCALE)
						             + int'(par_frac) * scale + offset_int;
						res.kind     = KIND_DISTANCE;
						res.distance = dist_val[24:0];
					end else begin
						res.kind = KIND_ERROR;
						res.text = par_text;
					end
				end
			end
			default: par_phase = PH_HUNT;
		endcase
	endfunction

	// Check result words, track register writes, predict accepted words
	always @(posedge clk) begin : track
		bit          produced;
		rfp_result_t predicted;
		rfp_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_frames.size() == 0) begin
					$error("result word with nothing pending: kind %0d", m_tuser);
					mismatches++;
				end else begin
					want = pending_frames.pop_front();
					if (m_tuser !== want.kind) begin
						$error("frame_kind: expected %0d, got %0d", want.kind, m_tuser);
						mismatches++;
					end
					if (m_tdata[24:0] !== want.distance) begin
						$error("distance_tenth_mm: expected %0d, got %0d",
						       want.distance, $signed(m_tdata[24:0]));
						mismatches++;
					end
					if (m_tdata[88:25] !== want.text) begin
						$error("error_text: expected %h, got %h", want.text, m_tdata[88:25]);
						mismatches++;
					end
					if (m_tdata[92:89] !== want.discarded) begin
						$error("discarded_bytes: expected %0d, got %0d",
						       want.discarded, m_tdata[92:89]);
						mismatches++;
					end
					if (m_tdata[95:93] !== 3'd0) begin
						$error("tdata padding: expected 0, got %0d", m_tdata[95:93]);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FINE:    set_fine    = cfg_data[0];
					REG_OFFSET:  set_offset  = cfg_data[20:0];
					REG_TIMEOUT: set_timeout = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				parse_rx_word(s_tuser, s_tdata, produced, predicted);
				if (pin_on)
					pending_frames.push_back(pin_res);
				else if (produced)
					pending_frames.push_back(predicted);
			end
		end
	end

	// Stall the result side in short bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rangefinder_ascii_frame_parser_top_tb: done, errors");
			$finish;
		end
	end

	// Offer one word, with an occasional gap ahead of it; return once accepted
	task automatic send_word(input logic op, input logic [7:0] b);
		int gap;
		if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// Hold the input until every pending result is out and the pipe is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic fine, input logic [20:0] offset,
	                             input logic [7:0] timeout, input bit spare);
		write_reg(REG_FINE, CFG_W'(fine));
		write_reg(REG_OFFSET, offset);
		write_reg(REG_TIMEOUT, CFG_W'(timeout));
		if (spare)
			write_reg(REG_SPARE, CFG_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Send one random sequence: mostly whole frames, some broken, some noise
	task automatic send_sequence();
		logic [7:0] fb[$];
		logic [7:0] total;
		logic [3:0] last_pos;
		int         pick;
		int         n;
		int         cut;
		int         decimals;
		bit         is_err;
		pick     = $urandom_range(0, 99);
		last_pos = set_fine ? POS_LAST_FINE : POS_LAST_STD;
		if (pick < 78) begin
			is_err = (pick >= 40 && pick < 60) || (pick >= 60 && $urandom_range(0, 1) == 1);
			fb = '{HDR_BYTE1, HDR_BYTE2, HDR_BYTE3};
			if (!is_err) begin
				decimals = set_fine ? 4 : 3;
				// now and then the wrong number of decimals for the resolution
				if ($urandom_range(0, 7) == 0)
					decimals = set_fine ? 3 : 4;
				repeat (3) fb.push_back(8'($urandom_range(DIGIT_ZERO, DIGIT_NINE)));
				fb.push_back(POINT_CHAR);
				repeat (decimals) fb.push_back(8'($urandom_range(DIGIT_ZERO, DIGIT_NINE)));
			end else begin
				fb.push_back(ERR_LEAD);
				repeat (last_pos - POS_TEXT0) fb.push_back(8'($urandom));
			end
			total = '0;
			foreach (fb[i]) total = total + fb[i];
			fb.push_back(8'h00 - total);
			// break the frame: bad byte, bad check byte or cut short
			if (pick >= 60) begin
				case ($urandom_range(0, 2))
					0: fb[$urandom_range(1, fb.size() - 1)] = 8'($urandom);
					1: fb[fb.size() - 1] = fb[fb.size() - 1] + 8'($urandom_range(1, 255));
					default: begin
						cut = $urandom_range(1, fb.size() - 1);
						while (fb.size() > cut) void'(fb.pop_back());
					end
				endcase
			end
			foreach (fb[i]) begin
				if ($urandom_range(0, 24) == 0)
					send_word(OP_TICK, 8'($urandom));
				send_word(OP_BYTE, fb[i]);
			end
		end else if (pick < 86) begin
			// silence run, at or just short of the timeout, or a shorter random run when the timeout is above 32
			if (set_timeout <= 8'd32)
				n = int'(set_timeout) - $urandom_range(0, 1);
			else
				n = ($urandom_range(0, 3) == 0) ? int'(set_timeout) : $urandom_range(1, 32);
			if (n < 1)
				n = 1;
			repeat (n) send_word(OP_TICK, 8'($urandom));
		end else if (pick < 95) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					send_word(OP_TICK, 8'($urandom));
				else if ($urandom_range(0, 7) == 0)
					send_word(OP_BYTE, HDR_BYTE1);
				else
					send_word(OP_BYTE, 8'($urandom));
			end
		end else begin
			settle();
		end
	endtask

	initial begin : stimulus
		int start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table under reset settings
		for (int r = 0; r < $size(DIRECTED); r++) begin
			pin_on  <= DIRECTED[r].pinned;
			pin_res <= DIRECTED[r].res;
			send_word(DIRECTED[r].op, DIRECTED[r].data);
		end
		pin_on <= 1'b0;
		settle();

		// Random phases, each under new settings; the last ones run without idling
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: load_settings(1'b0, CFG_W'(-1000000), 8'd1, 1'b1);
				1: load_settings(1'b1, CFG_W'(1000000), 8'd255, 1'b0);
				2: load_settings(1'b1, '0, 8'd0, 1'b0);
				3: load_settings(1'b0, 21'h100000, TIMEOUT_RESET, 1'b0);
				4: load_settings(1'b1, 21'h0FFFFF, 8'd3, 1'b0);
				default: load_settings(1'($urandom), CFG_W'($urandom),
				                       ($urandom_range(0, 3) == 0) ? 8'($urandom)
				                                                   : 8'($urandom_range(1, 40)),
				                       1'b0);
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			calm    = (p >= PHASES - 2);
			start   = words_sent;
			while (words_sent - start < PHASE_WORDS) send_sequence();
			settle();
		end

		if (mismatches == 0)
			$display("rangefinder_ascii_frame_parser_top_tb: done, clean");
		else
			$display("rangefinder_ascii_frame_parser_top_tb: done, errors");
		$finish;
	end

endmodule
